>>> rtl/tcw_pkg.sv
package tcw_pkg;

   // Screen geometry.
   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int TAB_CELLS   = 8;
   localparam int TOTAL_CELLS = COLUMNS * ROWS;

   localparam int COL_W     = $clog2(COLUMNS);
   localparam int ROW_W     = $clog2(ROWS + 1);
   localparam int ROW_IDX_W = $clog2(ROWS);
   localparam int CELL_W    = $clog2(TOTAL_CELLS + 1);
   localparam int ADDR_W    = $clog2(TOTAL_CELLS);

   // Field widths of the request and response items.
   localparam int FUNC_W      = 2;
   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int ROW_FIELD_W = 5;
   localparam int COL_FIELD_W = 7;
   localparam int CELL_DATA_W = CHAR_W + ATTR_W;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_ATTR_ADDR = 2'd0;

   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_HIGH  = 8'h80;
   localparam logic [ATTR_W-1:0] ATTR_DEFAULT = 8'h07;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUT   = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_SET   = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      FILL_NONE = 2'd0,
      FILL_LINE = 2'd1,
      FILL_TAB  = 2'd2
   } fill_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_EXEC  = 6'b000010,
      ST_WRITE = 6'b000100,
      ST_SWEEP = 6'b001000,
      ST_READ  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   // Physical row that shows a logical row, given the top of the row ring.
   function automatic logic [ROW_IDX_W-1:0] phys_row(input logic [ROW_IDX_W-1:0] logical,
                                                     input logic [ROW_IDX_W-1:0] top);
      logic [ROW_IDX_W:0] sum;
      sum = {1'b0, logical} + {1'b0, top};
      if (int'(sum) >= ROWS) begin
         sum = sum - (ROW_IDX_W + 1)'(ROWS);
      end
      return sum[ROW_IDX_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_IDX_W-1:0] prow,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(int'(prow) * COLUMNS + int'(col));
   endfunction

endpackage

>>> rtl/tcw_ram.sv
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule

>>> rtl/text_console_writer_top.sv
// Text console writer: an 80x25 screen of character/attribute cells and a cursor,
// kept as a ring of rows so that a scroll moves no data. Each request is handled
// alone and the request side is not ready until the previous one has finished.
// A read of a cell off the screen or in a row that still reads as zero skips
// the memory read. Newline and tab write one blank per cycle, once the row has
// been zeroed, through the single screen memory port, filling up to 80 cells.
// The first write into a row after reset, a clear or a scroll first zeroes
// that row, one cell a cycle; there is no clearing pass after reset, per-row
// valid bits stand in for it. A finished response waits in an output register,
// and the next request is accepted meanwhile; that request holds once it is
// done for as long as the output register is still full.
module text_console_writer_top (
   input  logic                             clock,
   input  logic                             reset,
   // Fields from bit 0 up: func[1:0], char_code[9:2], row[14:10], column[21:15].
   input  logic [tcw_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0 up: cell_char[7:0], cell_attr[15:8], cursor_row[20:16],
   // cursor_column[27:21], scrolled[28].
   output logic [tcw_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tcw_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   tcw_pkg::state_type                     state_ff, state_in;
   tcw_pkg::func_type                      func_ff, func_in;
   logic [tcw_pkg::CHAR_W-1:0]             code_ff, code_in;
   logic [tcw_pkg::ROW_FIELD_W-1:0]        row_ff, row_in;
   logic [tcw_pkg::COL_FIELD_W-1:0]        col_ff, col_in;
   tcw_pkg::fill_type                      fill_ff, fill_in;
   logic [tcw_pkg::CHAR_W-1:0]             char_ff, char_in;
   logic [tcw_pkg::ROW_W-1:0]              cur_row_ff, cur_row_in;
   logic [tcw_pkg::COL_W-1:0]              cur_col_ff, cur_col_in;
   logic [tcw_pkg::CELL_W-1:0]             cur_cell_ff, cur_cell_in;
   logic [tcw_pkg::ROW_IDX_W-1:0]          top_ff, top_in;
   logic [tcw_pkg::ROWS-1:0]               valid_ff, valid_in;
   logic [tcw_pkg::ATTR_W-1:0]             attr_ff, attr_in;
   logic [tcw_pkg::ROW_IDX_W-1:0]          sweep_row_ff, sweep_row_in;
   logic [tcw_pkg::COL_W-1:0]              sweep_col_ff, sweep_col_in;
   logic [tcw_pkg::CHAR_W-1:0]             res_char_ff, res_char_in;
   logic [tcw_pkg::ATTR_W-1:0]             res_attr_ff, res_attr_in;
   logic                                   res_scr_ff, res_scr_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::RSP_DATA_W-1:0]         rsp_data_ff, rsp_data_in;

   logic                                   ram_we;
   logic [tcw_pkg::ADDR_W-1:0]             ram_addr;
   logic [tcw_pkg::CELL_DATA_W-1:0]        ram_wdata;
   logic [tcw_pkg::CELL_DATA_W-1:0]        ram_rdata;

   logic [tcw_pkg::ROW_IDX_W-1:0]          cur_phys;
   logic [tcw_pkg::ROW_IDX_W-1:0]          rd_phys;
   logic [tcw_pkg::COL_W-1:0]              nxt_col;
   logic [tcw_pkg::ROW_W-1:0]              nxt_row;
   logic [tcw_pkg::CELL_W-1:0]             nxt_cell;
   logic                                   fill_stop;
   logic                                   rd_in_range;
   logic                                   csr_write;

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_DATA_W),
      .DEPTH (tcw_pkg::TOTAL_CELLS)
   ) u_screen (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign req_tready = (state_ff == tcw_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_paddr == tcw_pkg::CSR_ATTR_ADDR);
   assign csr_prdata = (csr_paddr == tcw_pkg::CSR_ATTR_ADDR)
                       ? tcw_pkg::CSR_DATA_W'(attr_ff) : '0;

   assign cur_phys = tcw_pkg::phys_row(cur_row_ff[tcw_pkg::ROW_IDX_W-1:0], top_ff);
   assign rd_phys  = tcw_pkg::phys_row(tcw_pkg::ROW_IDX_W'(row_ff), top_ff);
   assign rd_in_range = (int'(row_ff) < tcw_pkg::ROWS) && (int'(col_ff) < tcw_pkg::COLUMNS);

   // Cursor position after one cell write.
   always_comb begin
      if (int'(cur_col_ff) == tcw_pkg::COLUMNS - 1) begin
         nxt_col = '0;
         nxt_row = cur_row_ff + 1'b1;
      end else begin
         nxt_col = cur_col_ff + 1'b1;
         nxt_row = cur_row_ff;
      end
      nxt_cell = cur_cell_ff + 1'b1;
      case (fill_ff)
         tcw_pkg::FILL_LINE: fill_stop = (nxt_col == '0);
         tcw_pkg::FILL_TAB:  fill_stop = ((int'(nxt_cell) % tcw_pkg::TAB_CELLS) == 0);
         default:            fill_stop = 1'b1;
      endcase
      if (int'(nxt_row) == tcw_pkg::ROWS) begin
         fill_stop = 1'b1;
      end
   end

   // Screen memory port.
   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = tcw_pkg::cell_addr(cur_phys, cur_col_ff);
      ram_wdata = {attr_ff, char_ff};
      unique case (state_ff)
         tcw_pkg::ST_SWEEP: begin
            ram_we    = 1'b1;
            ram_addr  = tcw_pkg::cell_addr(sweep_row_ff, sweep_col_ff);
            ram_wdata = '0;
         end
         tcw_pkg::ST_WRITE: begin
            ram_we = valid_ff[cur_phys];
         end
         tcw_pkg::ST_EXEC: begin
            ram_addr = tcw_pkg::cell_addr(rd_phys, tcw_pkg::COL_W'(col_ff));
         end
         default: begin
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      code_in      = code_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      fill_in      = fill_ff;
      char_in      = char_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      cur_cell_in  = cur_cell_ff;
      top_in       = top_ff;
      valid_in     = valid_ff;
      attr_in      = csr_write ? csr_pwdata[tcw_pkg::ATTR_W-1:0] : attr_ff;
      sweep_row_in = sweep_row_ff;
      sweep_col_in = sweep_col_ff;
      res_char_in  = res_char_ff;
      res_attr_in  = res_attr_ff;
      res_scr_in   = res_scr_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               func_in  = tcw_pkg::func_type'(req_tdata[1:0]);
               code_in  = req_tdata[9:2];
               row_in   = req_tdata[14:10];
               col_in   = req_tdata[21:15];
               state_in = tcw_pkg::ST_EXEC;
            end
         end
         tcw_pkg::ST_EXEC: begin
            res_char_in = '0;
            res_attr_in = '0;
            res_scr_in  = 1'b0;
            state_in    = tcw_pkg::ST_DONE;
            unique case (func_ff)
               tcw_pkg::FUNC_PUT: begin
                  fill_in = tcw_pkg::FILL_NONE;
                  char_in = code_ff;
                  if (code_ff == tcw_pkg::CHAR_LF) begin
                     fill_in = tcw_pkg::FILL_LINE;
                     char_in = tcw_pkg::CHAR_BLANK;
                  end else if (code_ff == tcw_pkg::CHAR_TAB) begin
                     fill_in = tcw_pkg::FILL_TAB;
                     char_in = tcw_pkg::CHAR_BLANK;
                  end else if (code_ff < tcw_pkg::CHAR_BLANK || code_ff >= tcw_pkg::CHAR_HIGH) begin
                     char_in = tcw_pkg::CHAR_DOT;
                  end
                  // A carriage return leaves the screen and cursor as they are.
                  if (code_ff != tcw_pkg::CHAR_CR) begin
                     state_in = tcw_pkg::ST_WRITE;
                  end
               end
               tcw_pkg::FUNC_READ: begin
                  if (rd_in_range && valid_ff[rd_phys]) begin
                     state_in = tcw_pkg::ST_READ;
                  end
               end
               tcw_pkg::FUNC_SET: begin
                  cur_row_in = (int'(row_ff) > tcw_pkg::ROWS - 1)
                               ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)
                               : tcw_pkg::ROW_W'(row_ff);
                  cur_col_in = (int'(col_ff) > tcw_pkg::COLUMNS - 1)
                               ? tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)
                               : tcw_pkg::COL_W'(col_ff);
                  cur_cell_in = tcw_pkg::CELL_W'(int'(cur_row_in) * tcw_pkg::COLUMNS
                                                 + int'(cur_col_in));
               end
               tcw_pkg::FUNC_CLEAR: begin
                  valid_in    = '0;
                  cur_row_in  = '0;
                  cur_col_in  = '0;
                  cur_cell_in = '0;
                  top_in      = '0;
                  attr_in     = tcw_pkg::ATTR_DEFAULT;
               end
               default: begin
               end
            endcase
         end
         tcw_pkg::ST_WRITE: begin
            if (!valid_ff[cur_phys]) begin
               // The row still reads as zero; zero it in memory before the first write.
               sweep_row_in = cur_phys;
               sweep_col_in = '0;
               state_in     = tcw_pkg::ST_SWEEP;
            end else if (!fill_stop) begin
               cur_row_in  = nxt_row;
               cur_col_in  = nxt_col;
               cur_cell_in = nxt_cell;
            end else if (int'(nxt_row) == tcw_pkg::ROWS) begin
               // Ran past the last cell: drop the top row and start a fresh bottom row.
               valid_in[top_ff] = 1'b0;
               top_in = (int'(top_ff) == tcw_pkg::ROWS - 1) ? '0 : top_ff + 1'b1;
               cur_row_in  = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
               cur_col_in  = '0;
               cur_cell_in = tcw_pkg::CELL_W'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS);
               res_scr_in  = 1'b1;
               state_in    = tcw_pkg::ST_DONE;
            end else begin
               cur_row_in  = nxt_row;
               cur_col_in  = nxt_col;
               cur_cell_in = nxt_cell;
               state_in    = tcw_pkg::ST_DONE;
            end
         end
         tcw_pkg::ST_SWEEP: begin
            if (int'(sweep_col_ff) == tcw_pkg::COLUMNS - 1) begin
               valid_in[sweep_row_ff] = 1'b1;
               state_in = tcw_pkg::ST_WRITE;
            end else begin
               sweep_col_in = sweep_col_ff + 1'b1;
            end
         end
         tcw_pkg::ST_READ: begin
            res_char_in = ram_rdata[tcw_pkg::CHAR_W-1:0];
            res_attr_in = ram_rdata[tcw_pkg::CELL_DATA_W-1:tcw_pkg::CHAR_W];
            state_in    = tcw_pkg::ST_DONE;
         end
         tcw_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = tcw_pkg::RSP_DATA_W'({res_scr_ff,
                                                    tcw_pkg::COL_FIELD_W'(cur_col_ff),
                                                    tcw_pkg::ROW_FIELD_W'(cur_row_ff),
                                                    res_attr_ff, res_char_ff});
               state_in     = tcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::ST_IDLE;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         cur_cell_ff  <= '0;
         top_ff       <= '0;
         valid_ff     <= '0;
         attr_ff      <= tcw_pkg::ATTR_DEFAULT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         cur_cell_ff  <= cur_cell_in;
         top_ff       <= top_in;
         valid_ff     <= valid_in;
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      code_ff      <= code_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      fill_ff      <= fill_in;
      char_ff      <= char_in;
      sweep_row_ff <= sweep_row_in;
      sweep_col_ff <= sweep_col_in;
      res_char_ff  <= res_char_in;
      res_attr_ff  <= res_attr_in;
      res_scr_ff   <= res_scr_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

>>> verif/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tcw_pkg::*;

   typedef struct packed {
      logic [COL_FIELD_W-1:0] column;
      logic [ROW_FIELD_W-1:0] row;
      logic [CHAR_W-1:0]      code;
      func_type               func;
   } console_request_type;

   typedef struct packed {
      logic                   scrolled;
      logic [COL_FIELD_W-1:0] cursor_column;
      logic [ROW_FIELD_W-1:0] cursor_row;
      logic [ATTR_W-1:0]      cell_attr;
      logic [CHAR_W-1:0]      cell_char;
   } console_view_type;

   typedef struct {
      console_request_type rq;
      bit                  typed;
      console_view_type    want;
   } directed_entry_type;

   logic                  clock;
   logic                  reset;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Mirror of the screen, kept as the same ring of rows as the block uses.
   logic [CELL_DATA_W-1:0] screen_model [TOTAL_CELLS];
   int                     cursor_pos;
   int                     top_row;
   logic [ATTR_W-1:0]      attr_model;

   console_view_type   expected_views [$];
   directed_entry_type directed_table [$];
   int              error_count = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              phase = 0;
   int              hold_left = 0;
   bit              hold_done = 1'b0;

   text_console_writer_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("[text_console_writer_top] ERROR");
      $finish;
   end

   function automatic void clear_model();
      foreach (screen_model[i]) screen_model[i] = '0;
      cursor_pos = 0;
      top_row    = 0;
      attr_model = ATTR_DEFAULT;
   endfunction

   function automatic int phys_cell(int idx);
      return ((idx / COLUMNS + top_row) % ROWS) * COLUMNS + idx % COLUMNS;
   endfunction

   function automatic void put_cell(logic [CHAR_W-1:0] ch);
      if (cursor_pos < TOTAL_CELLS) begin
         screen_model[phys_cell(cursor_pos)] = {attr_model, ch};
      end
      cursor_pos++;
   endfunction

   // A fill always writes at least one blank, then stops at the next multiple
   // of the stop or at the last cell of the screen.
   function automatic void blank_until(int stop);
      do begin
         put_cell(CHAR_BLANK);
      end while (cursor_pos % stop != 0 && cursor_pos < TOTAL_CELLS);
   endfunction

   function automatic console_view_type console_apply(console_request_type rq);
      console_view_type v;
      int               r;
      int               c;
      logic [CELL_DATA_W-1:0] cell_word;
      v = '0;
      case (rq.func)
         FUNC_PUT: begin
            if (rq.code == CHAR_LF) begin
               blank_until(COLUMNS);
            end else if (rq.code == CHAR_TAB) begin
               blank_until(TAB_CELLS);
            end else if (rq.code != CHAR_CR) begin
               if (rq.code < CHAR_BLANK || rq.code >= CHAR_HIGH) begin
                  put_cell(CHAR_DOT);
               end else begin
                  put_cell(rq.code);
               end
            end
            if (cursor_pos >= TOTAL_CELLS) begin
               for (int i = 0; i < COLUMNS; i++) screen_model[top_row * COLUMNS + i] = '0;
               top_row    = (top_row + 1) % ROWS;
               cursor_pos = (ROWS - 1) * COLUMNS;
               v.scrolled = 1'b1;
            end
         end
         FUNC_READ: begin
            if (rq.row < ROWS && rq.column < COLUMNS) begin
               cell_word   = screen_model[phys_cell(rq.row * COLUMNS + rq.column)];
               v.cell_char = cell_word[CHAR_W-1:0];
               v.cell_attr = cell_word[CELL_DATA_W-1:CHAR_W];
            end
         end
         FUNC_SET: begin
            r = (rq.row > ROWS - 1) ? ROWS - 1 : int'(rq.row);
            c = (rq.column > COLUMNS - 1) ? COLUMNS - 1 : int'(rq.column);
            cursor_pos = r * COLUMNS + c;
         end
         FUNC_CLEAR: begin
            clear_model();
         end
      endcase
      v.cursor_row    = ROW_FIELD_W'(cursor_pos / COLUMNS);
      v.cursor_column = COL_FIELD_W'(cursor_pos % COLUMNS);
      return v;
   endfunction

   function automatic void add_entry(func_type f, int code, int row, int col,
                                     bit typed = 1'b0, int ch = 0, int at = 0,
                                     int crow = 0, int ccol = 0, bit scr = 1'b0);
      directed_entry_type e;
      e.rq.func             = f;
      e.rq.code             = CHAR_W'(code);
      e.rq.row              = ROW_FIELD_W'(row);
      e.rq.column           = COL_FIELD_W'(col);
      e.typed               = typed;
      e.want.cell_char      = CHAR_W'(ch);
      e.want.cell_attr      = ATTR_W'(at);
      e.want.cursor_row     = ROW_FIELD_W'(crow);
      e.want.cursor_column  = COL_FIELD_W'(ccol);
      e.want.scrolled       = scr;
      directed_table.push_back(e);
   endfunction

   function automatic console_request_type random_request();
      console_request_type rq;
      int                  pick;
      int                  kind;
      pick      = $urandom_range(0, 99);
      rq.code   = CHAR_W'($urandom_range(0, 255));
      rq.row    = ROW_FIELD_W'($urandom_range(0, 31));
      rq.column = COL_FIELD_W'($urandom_range(0, 127));
      if (pick < 2) begin
         rq.func = FUNC_CLEAR;
      end else if (pick < 20) begin
         rq.func = FUNC_READ;
         if ($urandom_range(0, 9) != 0) begin
            rq.row    = ROW_FIELD_W'($urandom_range(0, ROWS - 1));
            rq.column = COL_FIELD_W'($urandom_range(0, COLUMNS - 1));
         end
      end else if (pick < 32) begin
         rq.func = FUNC_SET;
         // Favor the bottom rows so that puts reach the end and scroll often.
         if ($urandom_range(0, 2) == 0) begin
            rq.row    = ROW_FIELD_W'($urandom_range(ROWS - 3, ROWS - 1));
            rq.column = COL_FIELD_W'($urandom_range(COLUMNS - 12, COLUMNS - 1));
         end
      end else begin
         rq.func = FUNC_PUT;
         kind    = $urandom_range(0, 99);
         if (kind < 10) begin
            rq.code = CHAR_LF;
         end else if (kind < 18) begin
            rq.code = CHAR_TAB;
         end else if (kind < 22) begin
            rq.code = CHAR_CR;
         end else if (kind < 30) begin
            rq.code = CHAR_W'($urandom_range(0, 31));
         end else if (kind < 40) begin
            rq.code = CHAR_W'($urandom_range(128, 255));
         end else begin
            rq.code = CHAR_W'($urandom_range(32, 127));
         end
      end
      return rq;
   endfunction

   // Offers one request and keeps it offered until the block takes it.
   task automatic send_request(console_request_type rq, bit typed, console_view_type want);
      console_view_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= REQ_DATA_W'(rq);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = console_apply(rq);
      expected_views.push_back(typed ? want : predicted);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
   endtask

   task automatic write_attribute(logic [ATTR_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ATTR_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      attr_model = value;
   endtask

   // Response side: random stalls, plus one long hold-off once the last phase
   // starts so that the request side backs up.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (phase == 2 && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= 400;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      console_view_type got;
      console_view_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(console_view_type)-1:0];
         if (expected_views.size() == 0) begin
            $error("response %h arrived with no request outstanding", got);
            error_count++;
         end else begin
            want = expected_views.pop_front();
            if (got.cell_char !== want.cell_char) begin
               $error("cell_char: expected %h, got %h", want.cell_char, got.cell_char);
               error_count++;
            end
            if (got.cell_attr !== want.cell_attr) begin
               $error("cell_attr: expected %h, got %h", want.cell_attr, got.cell_attr);
               error_count++;
            end
            if (got.cursor_row !== want.cursor_row) begin
               $error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
               error_count++;
            end
            if (got.cursor_column !== want.cursor_column) begin
               $error("cursor_column: expected %0d, got %0d",
                      want.cursor_column, got.cursor_column);
               error_count++;
            end
            if (got.scrolled !== want.scrolled) begin
               $error("scrolled: expected %0d, got %0d", want.scrolled, got.scrolled);
               error_count++;
            end
         end
      end
   end

   initial begin
      console_view_type none;
      logic [ATTR_W-1:0] phase_attr [3];
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      none = '0;
      clear_model();

      // Reset state, clamping and out-of-range reads, a put on the last cell,
      // carriage return, newline and tab, stored codes at both ends of the
      // printable range, a tab running off the screen, and a clear.
      add_entry(FUNC_READ, 0, 0, 0, 1, 0, 0, 0, 0, 0);
      add_entry(FUNC_SET, 255, 31, 127, 1, 0, 0, 24, 79, 0);
      add_entry(FUNC_READ, 0, 25, 0, 1, 0, 0, 24, 79, 0);
      add_entry(FUNC_READ, 0, 0, 80, 1, 0, 0, 24, 79, 0);
      add_entry(FUNC_READ, 0, 31, 127, 1, 0, 0, 24, 79, 0);
      add_entry(FUNC_PUT, 8'h41, 0, 0, 1, 0, 0, 24, 0, 1);
      add_entry(FUNC_READ, 0, 23, 79, 1, 8'h41, ATTR_DEFAULT, 24, 0, 0);
      add_entry(FUNC_PUT, CHAR_CR, 0, 0, 1, 0, 0, 24, 0, 0);
      add_entry(FUNC_PUT, CHAR_LF, 31, 127, 1, 0, 0, 24, 0, 1);
      add_entry(FUNC_SET, 0, 0, 3);
      add_entry(FUNC_PUT, CHAR_TAB, 0, 0, 1, 0, 0, 0, 8, 0);
      add_entry(FUNC_PUT, 8'h00, 0, 0);
      add_entry(FUNC_PUT, 8'h1F, 0, 0);
      add_entry(FUNC_PUT, 8'h7F, 0, 0);
      add_entry(FUNC_PUT, 8'h80, 0, 0);
      add_entry(FUNC_PUT, 8'hFF, 0, 0);
      add_entry(FUNC_PUT, 8'h20, 0, 0);
      add_entry(FUNC_PUT, 8'h7E, 0, 0);
      add_entry(FUNC_READ, 0, 0, 8, 1, CHAR_DOT, ATTR_DEFAULT, 0, 15, 0);
      add_entry(FUNC_READ, 0, 0, 10);
      add_entry(FUNC_READ, 0, 0, 14);
      add_entry(FUNC_SET, 0, 24, 77);
      add_entry(FUNC_PUT, CHAR_TAB, 0, 0, 1, 0, 0, 24, 0, 1);
      add_entry(FUNC_SET, 0, 5, 70);
      add_entry(FUNC_PUT, CHAR_LF, 0, 0);
      add_entry(FUNC_CLEAR, 255, 31, 127, 1, 0, 0, 0, 0, 0);
      add_entry(FUNC_READ, 0, 6, 5, 1, 0, 0, 0, 0, 0);

      phase_attr[0] = 8'hFF;
      phase_attr[1] = 8'h00;
      phase_attr[2] = ATTR_W'($urandom_range(1, 254));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 26;
      recv_idle_pct = 86;
      foreach (directed_table[i]) begin
         send_request(directed_table[i].rq, directed_table[i].typed, directed_table[i].want);
      end

      for (int p = 0; p < 3; p++) begin
         wait_drained();
         write_attribute(phase_attr[p]);
         send_idle_pct = (p == 0) ? 26 : (p == 1) ? 86 : 0;
         recv_idle_pct = (p == 0) ? 86 : (p == 1) ? 26 : 0;
         phase        <= p;
         repeat (430) send_request(random_request(), 1'b0, none);
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("[text_console_writer_top] OK");
      end else begin
         $display("[text_console_writer_top] ERROR");
      end
      $finish;
   end

endmodule
